// ----- rtl/core/tfe_pkg.sv -----
// Package for the telemetry frame encoder.
// Holds sizes, register indexes, byte selection codes and the command and
// status structs shared by the controller and the datapath. No dependencies.
package tfe_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDRESS = 1'd1;

    localparam logic [BYTE_W-1:0] START_BYTE_RST   = 8'hAA;
    localparam logic [BYTE_W-1:0] DEST_ADDRESS_RST = 8'hFF;

    typedef logic [2:0] byte_sel_t;

    localparam byte_sel_t SEL_START = 3'd0;
    localparam byte_sel_t SEL_DEST  = 3'd1;
    localparam byte_sel_t SEL_FUNC  = 3'd2;
    localparam byte_sel_t SEL_LEN   = 3'd3;
    localparam byte_sel_t SEL_PAY   = 3'd4;
    localparam byte_sel_t SEL_SUM   = 3'd5;
    localparam byte_sel_t SEL_ACC   = 3'd6;

    typedef struct packed {
        logic      take_input;
        logic      load;
        byte_sel_t sel;
        logic      idx_inc;
        logic      idx_clr;
        logic      frame_done;
    } tfe_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic out_free;
        logic count_zero;
        logic idx_at_end;
    } tfe_status_t;

endpackage

// ----- rtl/core/tfe_in_if.sv -----
// Input channel of the telemetry frame encoder: one payload byte per transaction.
// Depends on tfe_pkg for the byte width.
interface tfe_in_if
    import tfe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] func_id;
    logic [BYTE_W-1:0] payload_byte;
    logic              is_last;

    modport source (output valid, output func_id, output payload_byte, output is_last,
                    input ready);
    modport sink   (input valid, input func_id, input payload_byte, input is_last,
                    output ready);
endinterface

// ----- rtl/core/tfe_out_if.sv -----
// Output channel of the telemetry frame encoder: one frame byte per transaction.
// Depends on tfe_pkg for the byte width.
interface tfe_out_if
    import tfe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_end;
    logic              truncated;

    modport source (output valid, output frame_byte, output frame_end, output truncated,
                    input ready);
    modport sink   (input valid, input frame_byte, input frame_end, input truncated,
                    output ready);
endinterface

// ----- rtl/core/tfe_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/core/tfe_ctrl.sv -----
// Controller of the telemetry frame encoder: sequences collection and frame output.
// Depends on tfe_pkg for the command and status structs.
module tfe_ctrl
    import tfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tfe_status_t status,
    output tfe_cmd_t    cmd
);
    localparam logic [2:0] ST_COLLECT = 3'd0;
    localparam logic [2:0] ST_START   = 3'd1;
    localparam logic [2:0] ST_DEST    = 3'd2;
    localparam logic [2:0] ST_FUNC    = 3'd3;
    localparam logic [2:0] ST_LEN     = 3'd4;
    localparam logic [2:0] ST_PAY     = 3'd5;
    localparam logic [2:0] ST_SUM     = 3'd6;
    localparam logic [2:0] ST_ACC     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.sel        = SEL_START;
        unique case (state_reg)
            ST_COLLECT:
            begin
                cmd.take_input = 1'b1;
                if (status.in_fire && status.in_last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.sel = SEL_START;
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEST;
                end
            end
            ST_DEST:
            begin
                cmd.sel = SEL_DEST;
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FUNC;
                end
            end
            ST_FUNC:
            begin
                cmd.sel = SEL_FUNC;
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                cmd.sel = SEL_LEN;
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.count_zero ? ST_SUM : ST_PAY;
                end
            end
            ST_PAY:
            begin
                cmd.sel = SEL_PAY;
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    if (status.idx_at_end)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_SUM;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.sel = SEL_SUM;
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.sel = SEL_ACC;
                if (status.out_free)
                begin
                    cmd.load       = 1'b1;
                    cmd.frame_done = 1'b1;
                    state_next     = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end
endmodule

// ----- rtl/core/tfe_dp.sv -----
// Datapath of the telemetry frame encoder: configuration, payload buffer,
// checksums and the output register. Depends on tfe_pkg, the channel
// interfaces and tfe_ram.
module tfe_dp
    import tfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tfe_cmd_t              cmd,
    output tfe_status_t           status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tfe_in_if.sink                payload_ch,
    tfe_out_if.source             frame_ch
);
    logic [BYTE_W-1:0] start_reg;
    logic [BYTE_W-1:0] dest_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic [BYTE_W-1:0] held_func_reg;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] acc_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_end_reg;
    logic              out_trunc_reg;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] sel_byte;
    logic              in_fire;
    logic              count_full;
    logic              ram_we;
    logic              adds_to_sum;

    assign in_fire          = payload_ch.valid && cmd.take_input;
    assign payload_ch.ready = cmd.take_input;
    assign count_full       = (count_reg == CNT_W'(MAX_PAYLOAD));
    assign ram_we           = in_fire && !count_full;

    assign status.in_fire    = in_fire;
    assign status.in_last    = payload_ch.is_last;
    assign status.out_free   = !out_valid_reg || frame_ch.ready;
    assign status.count_zero = (count_reg == '0);
    assign status.idx_at_end = (CNT_W'(idx_reg + 1'b1) == count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_BYTE_RST;
            dest_reg  <= DEST_ADDRESS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_BYTE:   start_reg <= cfg_data;
                REG_DEST_ADDRESS: dest_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            held_func_reg <= '0;
        end
        else if (cmd.frame_done)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            if (count_reg == '0 && !ovf_reg)
            begin
                held_func_reg <= payload_ch.func_id;
            end
            if (count_full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = CNT_W'(idx_reg + 1'b1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    tfe_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (payload_ch.payload_byte),
        .raddr (idx_next[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        unique case (cmd.sel)
            SEL_START: sel_byte = start_reg;
            SEL_DEST:  sel_byte = dest_reg;
            SEL_FUNC:  sel_byte = held_func_reg;
            SEL_LEN:   sel_byte = BYTE_W'(count_reg);
            SEL_PAY:   sel_byte = ram_rdata;
            SEL_SUM:   sel_byte = sum_reg;
            SEL_ACC:   sel_byte = acc_reg;
            default:   sel_byte = '0;
        endcase
    end

    assign adds_to_sum = cmd.load && (cmd.sel != SEL_SUM) && (cmd.sel != SEL_ACC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            acc_reg <= '0;
        end
        else if (cmd.frame_done)
        begin
            sum_reg <= '0;
            acc_reg <= '0;
        end
        else if (adds_to_sum)
        begin
            sum_reg <= BYTE_W'(sum_reg + sel_byte);
            acc_reg <= BYTE_W'(acc_reg + sum_reg + sel_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_byte_reg  <= sel_byte;
            out_end_reg   <= (cmd.sel == SEL_ACC);
            out_trunc_reg <= ovf_reg;
        end
    end

    assign frame_ch.valid      = out_valid_reg;
    assign frame_ch.frame_byte = out_byte_reg;
    assign frame_ch.frame_end  = out_end_reg;
    assign frame_ch.truncated  = out_trunc_reg;
endmodule

// ----- rtl/core/telemetry_frame_encoder_unit.sv -----
// Top level of the telemetry frame encoder.
// Depends on tfe_pkg, tfe_in_if, tfe_out_if, tfe_ctrl and tfe_dp.
//
// Payload bytes arrive on payload_ch, one per transaction, and are held in a
// buffer of MAX_PAYLOAD entries; extra bytes are dropped and the frame is
// marked truncated. The transaction with is_last set closes the frame.
// The frame leaves on frame_ch, one byte per transaction: start byte,
// destination address, function id, length, the kept payload bytes, the
// byte sum and the sum of running sums, the last with frame_end set.
// While collecting, one payload byte is taken per cycle. A frame with N kept
// bytes takes N + 6 output transactions, one per cycle when the receiver is
// ready, and the buffer is read at that pace. The first byte is loaded into
// the output register from the start state. payload_ch.ready stays low from
// the closing transaction until the last frame byte is loaded into the
// output register. When frame_ch.ready is low the current byte holds and
// the sequence waits. The user must write start_byte and dest_address
// through cfg_we, cfg_index and cfg_data only while the block is idle; the
// block does not enforce this. Reset clears the buffer count and restores
// the register defaults; no clearing pass is needed.
module telemetry_frame_encoder_unit
    import tfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tfe_in_if.sink                payload_ch,
    tfe_out_if.source             frame_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    tfe_cmd_t    cmd;
    tfe_status_t status;

    tfe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    tfe_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .payload_ch (payload_ch),
        .frame_ch   (frame_ch)
    );
endmodule

// ----- rtl/core/tfe_checker.sv -----
// Port-level checker for the telemetry frame encoder, bound to the top level.
// Depends on tfe_pkg and telemetry_frame_encoder_unit.
module tfe_checker
    import tfe_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              in_last,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] frame_byte,
    input logic              frame_end,
    input logic              truncated
);
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("Input accepted right after a closing transaction.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !frame_end |=> out_valid)
        else $error("Gap inside a frame.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !frame_end |=> truncated == $past(truncated))
        else $error("Truncation flag changed inside a frame.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_end |-> !in_ready)
        else $error("Input ready while a frame is being sent.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte))
        else $error("Stalled frame byte changed.");
endmodule

bind telemetry_frame_encoder_unit tfe_checker u_tfe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (payload_ch.valid),
    .in_ready   (payload_ch.ready),
    .in_last    (payload_ch.is_last),
    .out_valid  (frame_ch.valid),
    .out_ready  (frame_ch.ready),
    .frame_byte (frame_ch.frame_byte),
    .frame_end  (frame_ch.frame_end),
    .truncated  (frame_ch.truncated)
);
